FILE: rtl/core/polar_table_bilinear_lookup_assert.svh
// Assertion macros for the polar table lookup
`ifndef POLAR_TABLE_BILINEAR_LOOKUP_ASSERT_SVH
`define POLAR_TABLE_BILINEAR_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PTBL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptbl assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define PTBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptbl assertion failed");

`endif

FILE: rtl/core/ptbl_pkg.sv
// Package: shared types and constants of the polar table lookup
package ptbl_pkg;

  localparam int ANGLE_W = 16;
  localparam int SPEED_W = 16;
  localparam int EROW_W  = 8;
  localparam int ECOL_W  = 6;
  localparam int VALUE_W = 16;
  localparam int PROD_W  = 25;   // angle word times 360
  localparam int DEG_W   = 9;    // rounded degree before folding, 0..360
  localparam int MIX_W   = 32;   // Q16.16 angle mix
  localparam int ACC_W   = 40;   // Q16.24 speed mix

  localparam logic [ANGLE_W-1:0] ANGLE_HALF_TURN = 16'h8000;
  localparam logic [PROD_W-1:0]  DEG_FULL        = 25'd360;
  localparam logic [PROD_W-1:0]  ROUND_HALF      = 25'd32768;
  localparam logic [DEG_W-1:0]   DEG_HALF        = 9'd180;
  localparam logic [DEG_W-1:0]   DEG_TURN        = 9'd360;
  localparam logic [ACC_W-1:0]   OUT_ROUND       = 40'h0000800000;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

endpackage

FILE: rtl/core/polar_table_bilinear_lookup.sv
// Polar boat speed table with bilinear lookup, four parity-banked memories.
//
// Items move at one per clock while the output side does not stall: a write or
// a lookup can then be transferred in every cycle, and its result passes through
// the stage 1 to stage 4 registers and then the output register. The table is
// split into four banks by row and column parity, each with one write port and
// one registered read port, so the four corners of a bilinear cell are read in
// the same cycle. Writes and reads happen in item order at the same pipeline
// stage, so a lookup always sees every earlier write. Table entries power up
// undefined; there is no clearing pass, and only written entries may be read.
`include "polar_table_bilinear_lookup_assert.svh"

module polar_table_bilinear_lookup
  import ptbl_pkg::*;
#(
  parameter int ANGLE_ROWS   = 181,
  parameter int WIND_COLUMNS = 61
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [ANGLE_W-1:0] in_wind_angle,
  input  logic [SPEED_W-1:0] in_wind_speed,
  input  logic [EROW_W-1:0]  in_entry_angle,
  input  logic [ECOL_W-1:0]  in_entry_wind,
  input  logic [VALUE_W-1:0] in_entry_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_boat_speed
);

  localparam int ROW_W      = (ANGLE_ROWS > 2) ? $clog2(ANGLE_ROWS) : 1;
  localparam int COL_W      = (WIND_COLUMNS > 2) ? $clog2(WIND_COLUMNS) : 1;
  localparam int ROWS_H     = (ANGLE_ROWS + 1) / 2;
  localparam int COLS_H     = (WIND_COLUMNS + 1) / 2;
  localparam int BANK_DEPTH = ROWS_H * COLS_H;
  localparam int BA_W       = (BANK_DEPTH > 2) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [SPEED_W-1:0] MAX_SPEED = SPEED_W'((WIND_COLUMNS - 1) * 256);

  function automatic logic [MIX_W-1:0] angle_mix(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b,
                                                 input logic [15:0] w);
    logic signed [16:0] d;
    logic signed [34:0] s;
    d = signed'({1'b0, b}) - signed'({1'b0, a});
    s = signed'({3'b000, a, 16'h0000}) + d * signed'({1'b0, w});
    return s[MIX_W-1:0];
  endfunction

  // config
  logic round_mode_r;

  // handshake
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv_out;
  logic in_xfer;

  // stage 1: angle product, saturated speed, write fields
  action_t             s1_act_r;
  logic [PROD_W-1:0]   s1_prod_r, s1_prod_nxt;
  logic [SPEED_W-1:0]  s1_spd_r, s1_spd_nxt;
  logic [EROW_W-1:0]   s1_erow_r;
  logic [ECOL_W-1:0]   s1_ecol_r;
  logic [VALUE_W-1:0]  s1_eval_r;
  logic                s1_wok_r, s1_wok_nxt;
  logic [ANGLE_W-1:0]  folded;

  // stage 2: read data and weights
  action_t             s2_act_r;
  logic                s2_r0p_r, s2_c0p_r, s2_last_r;
  logic [15:0]         s2_fa_r;
  logic [7:0]          s2_fs_r;

  // stage 2 address logic
  logic [DEG_W-1:0]    deg_rnd;
  logic [7:0]          deg;
  logic [15:0]         fa_nxt;
  logic [ROW_W-1:0]    r0, r1;
  logic [COL_W-1:0]    c0, c1;
  logic                last_col;
  logic [BA_W-1:0]     rd_addr [4];
  logic [BA_W-1:0]     wr_addr;
  logic [3:0]          bank_we;
  logic                bank_re;
  logic                addr_ok;
  logic [VALUE_W-1:0]  rd_q [4];

  // stage 3 / 4
  action_t             s3_act_r, s4_act_r;
  logic [MIX_W-1:0]    s3_vf_r, s3_vc_r;
  logic [7:0]          s3_fs_r;
  logic [ACC_W-1:0]    s4_t_r, s4_t_nxt;
  logic [VALUE_W-1:0]  a0, b0, a1, b1, lo_c0, lo_c1, hi_c0, hi_c1;
  logic [MIX_W-1:0]    vf_nxt, vc_nxt;
  logic [ACC_W-1:0]    rnd_sum;
  logic [VALUE_W-1:0]  out_boat_speed_r;

  // ---------------------------------------------------------------- control
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv4     = !v4_r || adv_out;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign in_xfer  = in_valid && adv1;

  assign out_valid      = out_valid_r;
  assign out_boat_speed = out_boat_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_mode_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        round_mode_r <= cfg_wdata;
      end
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv_out) out_valid_r <= v4_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    folded      = (in_wind_angle > ANGLE_HALF_TURN) ? (ANGLE_W'(0) - in_wind_angle)
                                                    : in_wind_angle;
    s1_prod_nxt = round_mode_r ? PROD_W'(in_wind_angle) * DEG_FULL
                               : PROD_W'(folded) * DEG_FULL;
    s1_spd_nxt  = (in_wind_speed > MAX_SPEED) ? MAX_SPEED : in_wind_speed;
    s1_wok_nxt  = (int'(in_entry_angle) < ANGLE_ROWS) &&
                  (int'(in_entry_wind) < WIND_COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_act_r  <= action_t'(in_action);
      s1_prod_r <= s1_prod_nxt;
      s1_spd_r  <= s1_spd_nxt;
      s1_erow_r <= in_entry_angle;
      s1_ecol_r <= in_entry_wind;
      s1_eval_r <= in_entry_value;
      s1_wok_r  <= s1_wok_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    deg_rnd = DEG_W'((s1_prod_r + ROUND_HALF) >> 16);
    if (round_mode_r) begin
      deg    = (deg_rnd > DEG_HALF) ? 8'(DEG_TURN - deg_rnd) : 8'(deg_rnd);
      fa_nxt = 16'h0000;
    end else begin
      deg    = s1_prod_r[23:16];
      fa_nxt = s1_prod_r[15:0];
    end
    // last row pairs with the one below it, weight zero
    if (int'(deg) >= ANGLE_ROWS - 1) begin
      r0     = ROW_W'(ANGLE_ROWS - 1);
      r1     = ROW_W'(ANGLE_ROWS - 2);
      fa_nxt = 16'h0000;
    end else begin
      r0 = ROW_W'(deg);
      r1 = ROW_W'(deg) + ROW_W'(1);
    end
    c0       = COL_W'(s1_spd_r[15:8]);
    last_col = int'(c0) >= WIND_COLUMNS - 1;
    c1       = last_col ? c0 : c0 + COL_W'(1);
  end

  // bank index is {row parity, column parity}
  always_comb begin
    logic [ROW_W-1:0] rs;
    logic [COL_W-1:0] cs;
    addr_ok = 1'b1;
    for (int b = 0; b < 4; b++) begin
      rs = (r0[0] == b[1]) ? r0 : r1;
      cs = (c0[0] == b[0]) ? c0 : c1;
      rd_addr[b] = BA_W'((int'(rs) >> 1) * COLS_H + (int'(cs) >> 1));
      addr_ok    = addr_ok && ((int'(rs) >> 1) * COLS_H + (int'(cs) >> 1) < BANK_DEPTH);
    end
    wr_addr = BA_W'((int'(s1_erow_r) >> 1) * COLS_H + (int'(s1_ecol_r) >> 1));
    bank_re = adv2 && v1_r && (s1_act_r == ACT_LOOKUP);
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = adv2 && v1_r && (s1_act_r == ACT_WRITE) && s1_wok_r &&
                   (s1_erow_r[0] == b[1]) && (s1_ecol_r[0] == b[0]);
    end
  end

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [VALUE_W-1:0] bank_mem [BANK_DEPTH];
    logic [VALUE_W-1:0] rdata_r;

    always_ff @(posedge clk) begin
      if (bank_we[gb]) begin
        bank_mem[wr_addr] <= s1_eval_r;
      end
    end

    always_ff @(posedge clk) begin
      if (bank_re) begin
        rdata_r <= bank_mem[rd_addr[gb]];
      end
    end

    assign rd_q[gb] = rdata_r;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_act_r  <= s1_act_r;
      s2_r0p_r  <= r0[0];
      s2_c0p_r  <= c0[0];
      s2_last_r <= last_col;
      s2_fa_r   <= fa_nxt;
      s2_fs_r   <= s1_spd_r[7:0];
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    lo_c0  = s2_c0p_r ? rd_q[1] : rd_q[0];
    lo_c1  = s2_c0p_r ? rd_q[0] : rd_q[1];
    hi_c0  = s2_c0p_r ? rd_q[3] : rd_q[2];
    hi_c1  = s2_c0p_r ? rd_q[2] : rd_q[3];
    a0     = s2_r0p_r ? hi_c0 : lo_c0;
    b0     = s2_r0p_r ? lo_c0 : hi_c0;
    a1     = s2_r0p_r ? hi_c1 : lo_c1;
    b1     = s2_r0p_r ? lo_c1 : hi_c1;
    vf_nxt = angle_mix(a0, b0, s2_fa_r);
    vc_nxt = s2_last_r ? vf_nxt : angle_mix(a1, b1, s2_fa_r);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_act_r <= s2_act_r;
      s3_vf_r  <= vf_nxt;
      s3_vc_r  <= vc_nxt;
      s3_fs_r  <= s2_fs_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    logic signed [32:0] d;
    logic signed [41:0] s;
    d        = signed'({1'b0, s3_vc_r}) - signed'({1'b0, s3_vf_r});
    s        = signed'({2'b00, s3_vf_r, 8'h00}) + d * signed'({1'b0, s3_fs_r});
    s4_t_nxt = s[ACC_W-1:0];  // convex mix, never negative
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_act_r <= s3_act_r;
      s4_t_r   <= s4_t_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  assign rnd_sum = s4_t_r + OUT_ROUND;

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_boat_speed_r <= (s4_act_r == ACT_LOOKUP) ? rnd_sum[39:24] : '0;
    end
  end

  // ---------------------------------------------------------------- checks
  `PTBL_ASSERT_NEXT(a_xfer_enters_pipe, in_xfer, v1_r)
  `PTBL_ASSERT_NEXT(a_held_result_kept, out_valid_r && out_stall && v4_r, v4_r && out_valid_r)
  `PTBL_ASSERT_NOW(a_read_addr_in_bank, bank_re, addr_ok)

endmodule
